// File: rtl/core/assert_macros.svh
// Assertion macros shared by the regulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SWP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/swp_pkg.sv
// Shared types, constants and the sine table of the sine-PWM regulator.
`default_nettype none

package swp_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS   = 12;
  localparam int LVL_W         = SAMPLE_BITS - 1;
  localparam int WIN_DEPTH     = 256;
  localparam int WIN_AW        = $clog2(WIN_DEPTH);
  localparam int SUM_W         = LVL_W + WIN_AW;
  localparam int HP_W          = 11;
  localparam int GAIN_W        = 12;
  localparam int TRIM_W        = 8;
  localparam int CMP_W         = 12;
  localparam int ERR_W         = 13;
  localparam int SINE_W        = 11;
  localparam int SINE_SHIFT    = 9;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 12;
  localparam int FRAC_BITS_DEF = 11;

  // Register reset values
  localparam logic [HP_W-1:0]        SETPOINT_RST   = 11'd1228;
  localparam logic [GAIN_W-1:0]      PROP_GAIN_RST  = 12'd102;
  localparam logic [GAIN_W-1:0]      INTEG_GAIN_RST = 12'd1;
  localparam logic [HP_W-1:0]        HALF_PER_RST   = 11'd300;
  localparam logic [SAMPLE_BITS-1:0] TRIP_LVL_RST   = 12'd3583;
  localparam logic [TRIM_W-1:0]      TRIM_RST       = 8'd75;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INTEG_GAIN  = 3'd2,
    REG_HALF_PERIOD = 3'd3,
    REG_TRIP_LEVEL  = 3'd4,
    REG_OFFSET_TRIM = 3'd5
  } cfg_reg_t;

  // Step strobes from the sequencer to the PI datapath
  typedef struct packed {
    logic ld_err;
    logic ld_mul;
    logic ld_integ;
    logic ld_amp;
    logic ld_sine;
    logic ld_cmp;
    logic clr;
  } swp_dp_ctl_t;

  // First quarter of the sine wave, peak 512, indexes 0 to 64
  localparam logic [9:0] SINE_QTR [0:64] = '{
    10'd0,   10'd13,  10'd25,  10'd38,  10'd50,  10'd63,  10'd75,  10'd88,
    10'd100, 10'd112, 10'd124, 10'd137, 10'd149, 10'd161, 10'd172, 10'd184,
    10'd196, 10'd207, 10'd219, 10'd230, 10'd241, 10'd252, 10'd263, 10'd274,
    10'd284, 10'd295, 10'd305, 10'd315, 10'd325, 10'd334, 10'd344, 10'd353,
    10'd362, 10'd371, 10'd379, 10'd388, 10'd396, 10'd404, 10'd411, 10'd419,
    10'd426, 10'd433, 10'd439, 10'd445, 10'd452, 10'd457, 10'd463, 10'd468,
    10'd473, 10'd478, 10'd482, 10'd486, 10'd490, 10'd493, 10'd497, 10'd500,
    10'd502, 10'd504, 10'd506, 10'd508, 10'd510, 10'd511, 10'd511, 10'd512,
    10'd512
  };

  // Negated sine step: fold the half period onto the quarter table
  function automatic logic signed [SINE_W-1:0] swp_neg_sine(input logic [WIN_AW-1:0] idx);
    logic [6:0] pos;
    logic [6:0] fold;
    logic signed [SINE_W-1:0] mag;
    pos  = idx[6:0];
    fold = (pos <= 7'd64) ? pos : 7'(8'd128 - {1'b0, pos});
    mag  = $signed({1'b0, SINE_QTR[fold]});
    return idx[7] ? mag : -mag;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/swp_window_mem.sv
// Sample window memory with per-entry valid bits and registered read.
`default_nettype none

module swp_window_mem
  import swp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              wr_en,
  input  logic [WIN_AW-1:0] addr,
  input  logic [LVL_W-1:0]  wr_data,
  output logic [LVL_W-1:0]  rd_level
);

  logic [LVL_W-1:0]     mem [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] valid_r;
  logic [LVL_W-1:0]     rd_data_r;
  logic                 rd_valid_r;

  // Synchronous write and read of the storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data_r <= mem[addr];
  end

  // Track written entries; drop them all at once on clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[addr];
      if (clr) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  // Entries never written since the last clear read as zero
  assign rd_level = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// File: rtl/core/swp_pi_datapath.sv
// PI controller and sine scaling datapath, one step per sequencer strobe.
`default_nettype none

module swp_pi_datapath
  import swp_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  swp_dp_ctl_t       ctl,
  input  logic [LVL_W-1:0]  avg_level,
  input  logic [HP_W-1:0]   setpoint,
  input  logic [GAIN_W-1:0] prop_gain,
  input  logic [GAIN_W-1:0] integ_gain,
  input  logic [HP_W-1:0]   half_period,
  input  logic [WIN_AW-1:0] slot,
  output logic [CMP_W-1:0]  compare
);

  localparam int INT_W  = HP_W + 2 + FRACTION_BITS;
  localparam int PROD_W = ERR_W + GAIN_W + 1;
  localparam int ACC_W  = ((INT_W > PROD_W) ? INT_W : PROD_W) + 2;
  localparam int AMP_W  = HP_W + 1;
  localparam int PS_W   = AMP_W + SINE_W;

  logic signed [ERR_W-1:0]  err_r, prev_r, esum_r;
  logic signed [ERR_W-1:0]  err_nxt, esum_nxt;
  logic signed [GAIN_W:0]   kp_s, ki_s;
  logic signed [PROD_W-1:0] prod_i_r, prod_p_r;
  logic signed [INT_W-1:0]  integ_r;
  logic signed [ACC_W-1:0]  lim_q, isum, integ_nxt;
  logic signed [ACC_W-1:0]  asum, ashr, hp_acc, amp_acc;
  logic signed [AMP_W-1:0]  amp_r;
  logic signed [PS_W-1:0]   prod_s_r;
  logic signed [PS_W-1:0]   prod_s_shr;
  logic signed [CMP_W:0]    cmp_sum;
  logic [CMP_W-1:0]         cmp_r;

  // Error against the setpoint and trapezoid sum
  assign err_nxt  = $signed({2'b00, setpoint}) - $signed({2'b00, avg_level});
  assign esum_nxt = err_nxt + prev_r;

  assign kp_s = $signed({1'b0, prop_gain});
  assign ki_s = $signed({1'b0, integ_gain});

  // Integrator update clamped to plus or minus half period in Q format
  assign lim_q = $signed({{(ACC_W - HP_W - FRACTION_BITS){1'b0}}, half_period,
                          {FRACTION_BITS{1'b0}}});
  assign isum  = ACC_W'(prod_i_r) + ACC_W'(integ_r);
  always_comb begin
    if (isum >= lim_q) begin
      integ_nxt = lim_q;
    end else if (isum <= -lim_q) begin
      integ_nxt = -lim_q;
    end else begin
      integ_nxt = isum;
    end
  end

  // Amplitude: integral plus proportional, back to integer, clamped
  assign asum   = ACC_W'(integ_r) + ACC_W'(prod_p_r);
  assign ashr   = asum >>> FRACTION_BITS;
  assign hp_acc = $signed({{(ACC_W - HP_W){1'b0}}, half_period});
  always_comb begin
    if (ashr >= hp_acc) begin
      amp_acc = hp_acc;
    end else if (ashr <= -hp_acc) begin
      amp_acc = -hp_acc;
    end else begin
      amp_acc = ashr;
    end
  end

  // Compare value around the half period
  assign prod_s_shr = prod_s_r >>> SINE_SHIFT;
  assign cmp_sum    = $signed({2'b00, half_period}) + (CMP_W + 1)'(prod_s_shr);

  // Loop state: previous error and integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else if (ctl.clr) begin
      prev_r  <= '0;
      integ_r <= '0;
    end else if (ctl.ld_integ) begin
      prev_r  <= err_r;
      integ_r <= INT_W'(integ_nxt);
    end
  end

  // Intermediate stage registers
  always_ff @(posedge clk) begin
    if (ctl.ld_err) begin
      err_r  <= err_nxt;
      esum_r <= esum_nxt;
    end
    if (ctl.ld_mul) begin
      prod_i_r <= esum_r * ki_s;
      prod_p_r <= err_r * kp_s;
    end
    if (ctl.ld_amp) begin
      amp_r <= AMP_W'(amp_acc);
    end
    if (ctl.ld_sine) begin
      prod_s_r <= amp_r * swp_neg_sine(slot);
    end
    if (ctl.ld_cmp) begin
      cmp_r <= cmp_sum[CMP_W-1:0];
    end
  end

  assign compare = cmp_r;

endmodule

`default_nettype wire

// File: rtl/core/sine_pwm_pi_amplitude_regulator_core.sv
// Sine-PWM amplitude regulator: sequencer, window update, config and output register.
//
// One transaction carries one ADC sample and the loop and drive switches, and
// gives one PWM compare result; a new one is accepted only in idle. With the
// loop running, the sequencer walks one read-modify-write of the 256-entry
// sample window memory (registered read, then update of the running sum) and
// then the PI and sine-scaling steps, each multiplier followed by a register.
// A tripped fault or a disabled loop skips the PI and sine-scaling steps. The
// result sits in an output register, and the next transaction is accepted
// while it waits to be taken. Window entries carry valid bits that are cleared
// at once at reset and when a disabled loop meets no latched fault, so there
// is no clearing pass and the block accepts right after reset. Configuration
// writes land at once and are meant for an idle block.
`default_nettype none

module sine_pwm_pi_amplitude_regulator_core
  import swp_pkg::*;
#(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Sample input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_BITS-1:0] in_volt_sample,
  input  logic                  in_loop_enable,
  input  logic                  in_drive_enable,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CMP_W-1:0]      out_compare_value,
  output logic                  out_drive_active,
  output logic                  out_fault_latched,
  output logic [LVL_W-1:0]      out_average_level,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TW = SAMPLE_BITS + 2;
  localparam logic signed [TW-1:0] SAMPLE_MID = TW'(1 << (SAMPLE_BITS - 1));
  localparam logic [TW-1:0]        MAG_TOP    = TW'((1 << LVL_W) - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_READ  = 10'b0000000010,
    S_UPD   = 10'b0000000100,
    S_ERR   = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_INTEG = 10'b0000100000,
    S_AMP   = 10'b0001000000,
    S_SINE  = 10'b0010000000,
    S_FIN   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [HP_W-1:0]        setpoint_r;
  logic [GAIN_W-1:0]      kp_r, ki_r;
  logic [HP_W-1:0]        hp_r;
  logic [SAMPLE_BITS-1:0] trip_level_r;
  logic signed [TRIM_W-1:0] trim_r;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   loop_r, drive_r;
  logic                   trip_r;
  logic [LVL_W-1:0]       mag_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [WIN_AW-1:0]      phase_r;

  logic signed [TW-1:0]   trimmed, centred;
  logic [TW-1:0]          mag_abs;
  logic [LVL_W-1:0]       mag_sat;
  logic                   trip_hit;

  logic                   in_fire, win_we, win_clr, out_load, active;
  logic [LVL_W-1:0]       win_old;
  logic [CMP_W-1:0]       dp_compare, park_cmp, cmp_sel;
  swp_dp_ctl_t            dp_ctl;

  logic                   out_valid_r;
  logic [CMP_W-1:0]       out_cmp_r;
  logic                   out_act_r, out_fault_r;
  logic [LVL_W-1:0]       out_avg_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= SETPOINT_RST;
      kp_r         <= PROP_GAIN_RST;
      ki_r         <= INTEG_GAIN_RST;
      hp_r         <= HALF_PER_RST;
      trip_level_r <= TRIP_LVL_RST;
      trim_r       <= $signed(TRIM_RST);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SETPOINT:    setpoint_r   <= cfg_wdata[HP_W-1:0];
        REG_PROP_GAIN:   kp_r         <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG_GAIN:  ki_r         <= cfg_wdata[GAIN_W-1:0];
        REG_HALF_PERIOD: hp_r         <= cfg_wdata[HP_W-1:0];
        REG_TRIP_LEVEL:  trip_level_r <= cfg_wdata[SAMPLE_BITS-1:0];
        REG_OFFSET_TRIM: trim_r       <= $signed(cfg_wdata[TRIM_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_UPD;
      S_UPD:   state_nxt = (trip_r || !loop_r) ? S_DONE : S_ERR;
      S_ERR:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_INTEG;
      S_INTEG: state_nxt = S_AMP;
      S_AMP:   state_nxt = S_SINE;
      S_SINE:  state_nxt = S_FIN;
      S_FIN:   state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_volt_sample;
      loop_r   <= in_loop_enable;
      drive_r  <= in_drive_enable;
    end
  end

  // Trim, trip check and rectified level
  assign trimmed  = $signed({2'b00, sample_r}) + $signed({{(TW - TRIM_W){trim_r[TRIM_W-1]}}, trim_r});
  assign trip_hit = (trimmed >= $signed({2'b00, trip_level_r}));
  assign centred  = trimmed - SAMPLE_MID;
  assign mag_abs  = centred[TW-1] ? TW'(-centred) : TW'(centred);
  assign mag_sat  = (mag_abs > MAG_TOP) ? MAG_TOP[LVL_W-1:0] : mag_abs[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      mag_r <= mag_sat;
    end
  end

  // Window update or clear; fault latch; phase advance
  assign win_we  = (state_r == S_UPD) && !trip_r && loop_r;
  assign win_clr = (state_r == S_UPD) && !trip_r && !loop_r;
  assign sum_nxt = sum_r - SUM_W'(win_old) + SUM_W'(mag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trip_r  <= 1'b0;
      sum_r   <= '0;
      phase_r <= '0;
    end else begin
      if (state_r == S_READ) begin
        trip_r <= trip_r | trip_hit;
      end
      if (win_we) begin
        sum_r <= sum_nxt;
      end else if (win_clr) begin
        sum_r <= '0;
      end
      if (state_r == S_FIN) begin
        phase_r <= phase_r + 1'b1;
      end
    end
  end

  swp_window_mem u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (win_clr),
    .wr_en    (win_we),
    .addr     (phase_r),
    .wr_data  (mag_r),
    .rd_level (win_old)
  );

  // PI and sine datapath strobes
  assign dp_ctl.ld_err   = (state_r == S_ERR);
  assign dp_ctl.ld_mul   = (state_r == S_MUL);
  assign dp_ctl.ld_integ = (state_r == S_INTEG);
  assign dp_ctl.ld_amp   = (state_r == S_AMP);
  assign dp_ctl.ld_sine  = (state_r == S_SINE);
  assign dp_ctl.ld_cmp   = (state_r == S_FIN);
  assign dp_ctl.clr      = win_clr;

  swp_pi_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_pi (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (dp_ctl),
    .avg_level   (sum_r[SUM_W-1:WIN_AW]),
    .setpoint    (setpoint_r),
    .prop_gain   (kp_r),
    .integ_gain  (ki_r),
    .half_period (hp_r),
    .slot        (phase_r),
    .compare     (dp_compare)
  );

  // Pick the compare: parked, centered, or computed
  assign active   = drive_r && !trip_r;
  assign park_cmp = {hp_r, 1'b0};
  assign cmp_sel  = !active ? park_cmp : (loop_r ? dp_compare : {1'b0, hp_r});

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cmp_r   <= cmp_sel;
      out_act_r   <= active;
      out_fault_r <= trip_r;
      out_avg_r   <= sum_r[SUM_W-1:WIN_AW];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_compare_value = out_cmp_r;
  assign out_drive_active  = out_act_r;
  assign out_fault_latched = out_fault_r;
  assign out_average_level = out_avg_r;

  // Checks
`include "assert_macros.svh"
  `SWP_ASSERT_NEXT(a_fault_sticky, trip_r, trip_r, "fault latch cleared without reset")
  `SWP_ASSERT_SAME(a_no_drive_on_fault, out_valid, !(out_drive_active && out_fault_latched), "drive active with fault latched")
  `SWP_ASSERT_SAME(a_cmp_bound, out_valid, out_compare_value <= park_cmp, "compare above full period")
  `SWP_ASSERT_NEXT(a_hold_result, (state_r == S_DONE) && out_valid && !out_ready, state_r == S_DONE, "pending result overwritten")

endmodule

`default_nettype wire
